// ===== rtl/core/sbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial block chi-square package
// Shared widths, status codes and length helpers.
// ----------------------------------------------------------------------------
package sbcs_pkg;

  localparam int MAX_BLOCK_LENGTH = 8;
  localparam int COUNT_WIDTH      = 16;
  localparam int CFG_WIDTH        = 4;
  localparam int BIN_AW           = MAX_BLOCK_LENGTH;
  localparam int BIN_COUNT        = 1 << BIN_AW;
  localparam int FRAC_BITS        = 16;
  localparam int INT_BITS         = 24;
  localparam int CHI_WIDTH        = INT_BITS + FRAC_BITS;
  localparam int SUM_WIDTH        = 2 * COUNT_WIDTH + BIN_AW;
  localparam int DIV_WIDTH        = SUM_WIDTH + MAX_BLOCK_LENGTH + FRAC_BITS;
  localparam int DIV_CNT_W        = $clog2(DIV_WIDTH);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_AW-1:0]      bin_addr_t;
  typedef logic [CFG_WIDTH-1:0]   len_t;
  typedef logic [DIV_WIDTH-1:0]   div_word_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  function automatic len_t eff_length(input len_t v);
    len_t r;
    if (v == len_t'(0)) begin
      r = len_t'(1);
    end else if (v > len_t'(MAX_BLOCK_LENGTH)) begin
      r = len_t'(MAX_BLOCK_LENGTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic bin_addr_t len_mask(input len_t m);
    bin_addr_t r;
    for (int i = 0; i < BIN_AW; i++) begin
      r[i] = (len_t'(i) < m);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sbcs_div.sv =====
// ----------------------------------------------------------------------------
// Serial block chi-square divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sbcs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sbcs_pkg::div_word_t dividend,
  input  sbcs_pkg::count_t   divisor,
  output logic               done,
  output sbcs_pkg::div_word_t quotient
);
  import sbcs_pkg::*;

  localparam int REM_W = COUNT_WIDTH + 1;

  count_t                rem;
  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [REM_W-1:0]      trial;
  logic [REM_W:0]        diff;
  logic                  ge;

  always_comb begin
    trial = {rem, quotient[DIV_WIDTH-1]};
    diff  = {1'b0, trial} - {2'b00, divisor};
    ge    = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      cnt      <= DIV_CNT_W'(DIV_WIDTH - 1);
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      quotient <= {quotient[DIV_WIDTH-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy) && $past(cnt) == '0)
    else $error("divider done without finishing its steps");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == DIV_CNT_W'(DIV_WIDTH - 1))
    else $error("divider did not load on start");

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("divider done and busy together");

endmodule

// ===== rtl/core/serial_block_chi_square.sv =====
// ----------------------------------------------------------------------------
// Serial block chi-square test
// Bits are packed MSB first into non-overlapping blocks of block_length bits
// (0 acts as 1, above 8 acts as 8); each full block bumps its bin in a
// 256-entry histogram of saturating 16-bit counters held in a memory with
// one read and one write port. A bit that completes a block adds the
// BIN_UPDATE state, which writes back the incremented count read for it.
// The bit marked last_bit adds a walk over all 256 bins (squaring each count
// with one multiplier and clearing the bin), a pipeline drain and the 64-bit
// division of the one-bit-per-cycle divider before the result is offered.
// Input is taken again once the result is registered, even if it has not yet
// been read. After reset a pass over all 256 bins zeroes the histogram,
// during which no bit is taken.
// ----------------------------------------------------------------------------
module serial_block_chi_square (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  sbcs_pkg::len_t                   block_length,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             data_bit,
  input  logic                             last_bit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbcs_pkg::CHI_WIDTH-1:0]   chi_square,
  output sbcs_pkg::count_t                 full_blocks,
  output sbcs_pkg::status_t                status
);
  import sbcs_pkg::*;

  typedef enum logic [2:0] {
    CLEAR, IDLE, BIN_UPDATE, WALK, DRAIN, DIVIDE, FINISH
  } state_t;

  state_t                 state;
  len_t                   cfg_length;
  len_t                   run_length;
  bin_addr_t              partial_block;
  len_t                   bit_position;
  count_t                 block_total;
  logic                   overflow_seen;
  logic                   last_pend;
  bin_addr_t              bin_idx;
  bin_addr_t              walk_idx;
  logic                   rd_valid;
  logic                   sq_valid;
  logic [2*COUNT_WIDTH-1:0] sq;
  logic [SUM_WIDTH-1:0]   sum;

  count_t                 bin_mem [BIN_COUNT];
  count_t                 rd_data;
  bin_addr_t              rd_addr;
  bin_addr_t              wr_addr;
  count_t                 wr_data;
  logic                   wr_en;

  len_t                   m;
  bin_addr_t              pb_next;
  len_t                   pos_next;
  logic                   blk_done;
  logic                   in_accept;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  div_word_t              dividend;
  div_word_t              quotient;
  div_word_t              k_scaled;
  div_word_t              chi_diff;
  logic                   chi_below;
  logic                   chi_big;
  logic [CHI_WIDTH-1:0]   chi_val;
  status_t                status_val;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == DRAIN) && !rd_valid && !sq_valid;

  always_comb begin
    m        = eff_length(cfg_length);
    pb_next  = {partial_block[BIN_AW-2:0], data_bit};
    pos_next = bit_position + 1'b1;
    blk_done = (pos_next >= m);
  end

  always_comb begin
    rd_addr = (state == IDLE) ? (pb_next & len_mask(m)) : walk_idx;
    wr_en   = (state == BIN_UPDATE) || (state == CLEAR) || (state == WALK);
    wr_addr = (state == BIN_UPDATE) ? bin_idx : walk_idx;
    if (state == BIN_UPDATE && rd_data != '1) begin
      wr_data = rd_data + count_t'(1);
    end else if (state == BIN_UPDATE) begin
      wr_data = rd_data;
    end else begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= bin_mem[rd_addr];
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    dividend  = div_word_t'({sum, {FRAC_BITS{1'b0}}}) << run_length;
    k_scaled  = div_word_t'({block_total, {FRAC_BITS{1'b0}}});
    chi_below = (quotient < k_scaled);
    chi_diff  = quotient - k_scaled;
    chi_big   = |chi_diff[DIV_WIDTH-1:CHI_WIDTH];
    if (block_total == '0 || chi_below) begin
      chi_val = '0;
    end else if (chi_big) begin
      chi_val = '1;
    end else begin
      chi_val = chi_diff[CHI_WIDTH-1:0];
    end
    if (block_total == '0) begin
      status_val = STATUS_EMPTY;
    end else if (overflow_seen || (!chi_below && chi_big)) begin
      status_val = STATUS_OVERFLOW;
    end else begin
      status_val = STATUS_OK;
    end
  end

  sbcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (block_total),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CLEAR;
      cfg_length    <= len_t'(3);
      run_length    <= len_t'(3);
      partial_block <= '0;
      bit_position  <= '0;
      block_total   <= '0;
      overflow_seen <= 1'b0;
      last_pend     <= 1'b0;
      walk_idx      <= '0;
      rd_valid      <= 1'b0;
      sq_valid      <= 1'b0;
      sum           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_length <= block_length;
      end
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      rd_valid <= (state == WALK);
      sq_valid <= rd_valid;
      sq       <= rd_data * rd_data;
      if (sq_valid) begin
        sum <= sum + SUM_WIDTH'(sq);
      end
      unique case (state)
        CLEAR: begin
          walk_idx <= walk_idx + 1'b1;
          if (walk_idx == '1) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_accept) begin
            run_length <= m;
            last_pend  <= last_bit;
            walk_idx   <= '0;
            if (blk_done) begin
              bin_idx       <= pb_next & len_mask(m);
              partial_block <= '0;
              bit_position  <= '0;
              if (block_total != '1) begin
                block_total <= block_total + 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
              state <= BIN_UPDATE;
            end else if (last_bit) begin
              partial_block <= '0;
              bit_position  <= '0;
              state         <= WALK;
            end else begin
              partial_block <= pb_next;
              bit_position  <= pos_next;
            end
          end
        end
        BIN_UPDATE: begin
          if (rd_data == '1) begin
            overflow_seen <= 1'b1;
          end
          state <= last_pend ? WALK : IDLE;
        end
        WALK: begin
          walk_idx <= walk_idx + 1'b1;
          if (walk_idx == '1) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (div_start) begin
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            chi_square    <= chi_val;
            full_blocks   <= block_total;
            status        <= status_val;
            block_total   <= '0;
            overflow_seen <= 1'b0;
            sum           <= '0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    bit_position <= len_t'(MAX_BLOCK_LENGTH))
    else $error("bit position beyond longest block");

  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    state == DIVIDE |-> $stable(sum))
    else $error("sum changed during division");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> block_total == '0 && !overflow_seen && sum == '0)
    else $error("sequence state not cleared with result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == STATUS_EMPTY |-> chi_square == '0 && full_blocks == '0)
    else $error("empty result carries a statistic");

endmodule
